// ----- hdl/g_limited_elevator_scaler_assert.svh -----
// Assertion macros for the g-limited elevator scaler.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef G_LIMITED_ELEVATOR_SCALER_ASSERT_SVH
`define G_LIMITED_ELEVATOR_SCALER_ASSERT_SVH

// same-cycle implication
`define GLES_AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLES_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gles_pkg.sv -----
// Shared types and constants for the g-limited elevator scaler.
// No dependencies; imported by gles_unit, g_limited_elevator_scaler and the testbench.
package gles_pkg;

  // register reset values
  localparam logic [14:0]        G_LIMIT_HIGH_RST = 15'd9216;
  localparam logic signed [15:0] G_LIMIT_LOW_RST  = -16'sd3072;
  localparam logic [14:0]        GUARD_BAND_RST   = 15'd1536;
  localparam logic [13:0]        STALL_ANGLE_RST  = 14'd2867;

  // fixed-point constants
  localparam logic [16:0]        ONE_Q15   = 17'd32768;
  localparam logic [16:0]        ONE_Q16   = 17'd65536;
  localparam logic [16:0]        GAIN_BASE = 17'd3277;   // 0.05 in Q0.16
  localparam logic [16:0]        SMOOTH_K  = 17'd98304;  // 3.0 in Q2.15
  localparam logic [33:0]        ROUND_Q16 = 34'd32768;
  localparam logic signed [35:0] ROUND_Q15 = 36'sd16384;

  // band fraction divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 15;
  typedef logic [3:0] div_cnt_t;
  localparam div_cnt_t DIV_LAST = div_cnt_t'(DIV_STEPS - 1);

  // register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_G_LIMIT_HIGH = 2'd0,
    REG_G_LIMIT_LOW  = 2'd1,
    REG_GUARD_BAND   = 2'd2,
    REG_STALL_ANGLE  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } state_t;

  // shared unit request / response
  typedef struct packed {
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic [14:0]        rem;
    logic [14:0]        divisor;
  } unit_req_t;

  typedef struct packed {
    logic signed [35:0] prod;
    logic [14:0]        rem;
    logic               qbit;
  } unit_rsp_t;

endpackage

// ----- hdl/gles_unit.sv -----
// Shared arithmetic unit: one 18x18 signed multiplier and one restoring
// divide step. Depends on gles_pkg for the request/response structs.
module gles_unit
  import gles_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic signed [17:0] a;
  logic signed [17:0] b;
  logic [15:0]        rem2;
  logic [15:0]        dvs;
  logic               ge;

  // multiplier, then restoring divide step: shift in a zero, subtract if it fits
  always_comb begin
    a = req.mul_a;
    b = req.mul_b;
    rsp.prod = a * b;
    rem2 = {req.rem, 1'b0};
    dvs  = {1'b0, req.divisor};
    ge   = (rem2 >= dvs);
    rsp.qbit = ge;
    rsp.rem  = ge ? 15'(rem2 - dvs) : rem2[14:0];
  end

endmodule

// ----- hdl/g_limited_elevator_scaler.sv -----
// G-limited elevator scaler, top level.
// Depends on gles_pkg, gles_unit and g_limited_elevator_scaler_assert.svh.
//
// Usage:
//   Input words (g_load, attack_angle, elevator_command, step_time) enter on
//   a valid/ready channel; each gives one result word (elevator_out,
//   scale_now) on a valid/ready output channel with an output register.
//   in_ready is high only while the sequencer is idle. An item passes
//   through the check, mix and output states when no guard band applies;
//   with the band, the band fraction is first divided one bit per cycle,
//   then smoothstep and the filter run through one shared multiplier, one
//   product per cycle. The next item may be accepted in the cycle after
//   the result is loaded, while it still waits at the output.
//   If the receiver stalls with a result pending, the sequencer
//   holds the next result until the output register frees.
//   Reset (rst_n low, synchronous) returns the registers to their defaults,
//   clears the stored scale to zero and drops out_valid.
//   Registers are written over the APB port; write them only while idle.
module g_limited_elevator_scaler
  import gles_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_g_load,
  input  logic signed [15:0] in_attack_angle,
  input  logic signed [15:0] in_elevator_command,
  input  logic [15:0]        in_step_time,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_elevator_out,
  output logic [15:0]        out_scale_now
);

  // configuration registers
  logic [14:0]        g_limit_high_r;
  logic signed [15:0] g_limit_low_r;
  logic [14:0]        guard_band_r;
  logic [13:0]        stall_angle_r;
  reg_idx_t           cfg_idx;
  logic               cfg_we;

  // sequencer
  state_t             state_r, state_nxt;
  div_cnt_t           div_cnt_r, div_cnt_nxt;

  // item and working registers
  logic signed [15:0] g_r, g_nxt;
  logic signed [15:0] alpha_r, alpha_nxt;
  logic signed [15:0] cmd_r, cmd_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic [16:0]        u_r, u_nxt;
  logic [15:0]        f_r, f_nxt;
  logic [14:0]        rem_r, rem_nxt;
  logic [14:0]        t_r, t_nxt;
  logic [14:0]        t2_r, t2_nxt;
  logic [33:0]        acc_r, acc_nxt;
  logic [15:0]        scale_r, scale_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] eo_r, eo_nxt;
  logic [15:0]        scale_out_r, scale_out_nxt;

  // decision signals
  logic               cmd_pos, cmd_neg;
  logic signed [17:0] g_x, alpha_x, hi_x, lo_x, eps_x, stall_x;
  logic signed [17:0] dist_hi, dist_lo;
  logic               f_zero, band_hi, band_lo;
  logic [16:0]        u_sum, u_sat;
  logic               out_free;

  // shared unit
  unit_req_t          ureq;
  unit_rsp_t          ursp;
  logic [16:0]        smooth_k;
  logic [33:0]        mix;
  logic [16:0]        scale_raw;
  logic signed [35:0] eo_sum;

  gles_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  // APB register file
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_limit_high_r <= G_LIMIT_HIGH_RST;
      g_limit_low_r  <= G_LIMIT_LOW_RST;
      guard_band_r   <= GUARD_BAND_RST;
      stall_angle_r  <= STALL_ANGLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_G_LIMIT_HIGH: g_limit_high_r <= pwdata[14:0];
        REG_G_LIMIT_LOW:  g_limit_low_r  <= pwdata[15:0];
        REG_GUARD_BAND:   guard_band_r   <= pwdata[14:0];
        REG_STALL_ANGLE:  stall_angle_r  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_G_LIMIT_HIGH: prdata = {17'd0, g_limit_high_r};
      REG_G_LIMIT_LOW:  prdata = {{16{g_limit_low_r[15]}}, g_limit_low_r};
      REG_GUARD_BAND:   prdata = {17'd0, guard_band_r};
      REG_STALL_ANGLE:  prdata = {18'd0, stall_angle_r};
      default:          prdata = '0;
    endcase
  end

  // limit decision, wide signed compares
  always_comb begin
    cmd_pos = !cmd_r[15] && (cmd_r != '0);
    cmd_neg = cmd_r[15];
    g_x     = {{2{g_r[15]}}, g_r};
    alpha_x = {{2{alpha_r[15]}}, alpha_r};
    hi_x    = {3'd0, g_limit_high_r};
    lo_x    = {{2{g_limit_low_r[15]}}, g_limit_low_r};
    eps_x   = {3'd0, guard_band_r};
    stall_x = {4'd0, stall_angle_r};
    dist_hi = hi_x - g_x;
    dist_lo = g_x - lo_x;
    f_zero  = (cmd_pos && (g_x > hi_x)) || (cmd_neg && (g_x < lo_x))
              || (cmd_pos && (alpha_x > stall_x));
    band_hi = !f_zero && cmd_pos && (g_x > (hi_x - eps_x));
    band_lo = !f_zero && !band_hi && cmd_neg && (g_x < (lo_x + eps_x));
    u_sum   = GAIN_BASE + {1'b0, dt_r};
    u_sat   = (u_sum > ONE_Q16) ? ONE_Q16 : u_sum;
  end

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (band_hi || band_lo) ? ST_DIV : ST_MIX1;
      ST_DIV:   if (div_cnt_r == DIV_LAST) state_nxt = ST_SQ;
      ST_SQ:    state_nxt = ST_CUBE;
      ST_CUBE:  state_nxt = ST_MIX1;
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and unit operands
  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    smooth_k     = SMOOTH_K - {1'b0, t_r, 1'b0};
    ureq.mul_a   = '0;
    ureq.mul_b   = '0;
    ureq.rem     = rem_r;
    ureq.divisor = guard_band_r;
    case (state_r)
      ST_SQ: begin
        ureq.mul_a = {3'd0, t_r};
        ureq.mul_b = {3'd0, t_r};
      end
      ST_CUBE: begin
        ureq.mul_a = {3'd0, t2_r};
        ureq.mul_b = {1'b0, smooth_k};
      end
      ST_MIX1: begin
        ureq.mul_a = {1'b0, 17'(ONE_Q16 - u_r)};
        ureq.mul_b = {2'd0, scale_r};
      end
      ST_MIX2: begin
        ureq.mul_a = {1'b0, u_r};
        ureq.mul_b = {2'd0, f_r};
      end
      ST_OUT: begin
        ureq.mul_a = {{2{cmd_r[15]}}, cmd_r};
        ureq.mul_b = {2'd0, scale_r};
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    g_nxt         = g_r;
    alpha_nxt     = alpha_r;
    cmd_nxt       = cmd_r;
    dt_nxt        = dt_r;
    u_nxt         = u_r;
    f_nxt         = f_r;
    rem_nxt       = rem_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    acc_nxt       = acc_r;
    scale_nxt     = scale_r;
    div_cnt_nxt   = div_cnt_r;
    eo_nxt        = eo_r;
    scale_out_nxt = scale_out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mix           = acc_r + 34'(ursp.prod) + ROUND_Q16;
    scale_raw     = mix[32:16];
    eo_sum        = ursp.prod + ROUND_Q15;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          g_nxt     = in_g_load;
          alpha_nxt = in_attack_angle;
          cmd_nxt   = in_elevator_command;
          dt_nxt    = in_step_time;
        end
      end
      ST_CHECK: begin
        u_nxt       = u_sat;
        f_nxt       = f_zero ? 16'd0 : ONE_Q15[15:0];
        rem_nxt     = band_hi ? dist_hi[14:0] : dist_lo[14:0];
        t_nxt       = '0;
        div_cnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt     = ursp.rem;
        t_nxt       = {t_r[13:0], ursp.qbit};
        div_cnt_nxt = div_cnt_r + div_cnt_t'(1);
      end
      ST_SQ:   t2_nxt  = ursp.prod[29:15];
      ST_CUBE: f_nxt   = ursp.prod[30:15];
      ST_MIX1: acc_nxt = ursp.prod[33:0];
      ST_MIX2: scale_nxt = (scale_raw > ONE_Q15) ? ONE_Q15[15:0] : scale_raw[15:0];
      ST_OUT: begin
        if (out_free) begin
          eo_nxt        = eo_sum[30:15];
          scale_out_nxt = scale_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      scale_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      scale_r     <= scale_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    g_r         <= g_nxt;
    alpha_r     <= alpha_nxt;
    cmd_r       <= cmd_nxt;
    dt_r        <= dt_nxt;
    u_r         <= u_nxt;
    f_r         <= f_nxt;
    rem_r       <= rem_nxt;
    t_r         <= t_nxt;
    t2_r        <= t2_nxt;
    acc_r       <= acc_nxt;
    div_cnt_r   <= div_cnt_nxt;
    eo_r        <= eo_nxt;
    scale_out_r <= scale_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_elevator_out = eo_r;
  assign out_scale_now    = scale_out_r;

  // checks
`include "g_limited_elevator_scaler_assert.svh"

  `GLES_AST_IMPL(a_scale_le_one, 1'b1, scale_r <= ONE_Q15[15:0], "scale above one")
  `GLES_AST_NEXT(a_accept_starts, in_valid && in_ready, state_r == ST_CHECK, "accept lost")
  `GLES_AST_NEXT(a_div_ends, (state_r == ST_DIV) && (div_cnt_r == DIV_LAST), state_r == ST_SQ, "divide overran")
  `GLES_AST_NEXT(a_out_hold, (state_r == ST_OUT) && out_valid_r && !out_ready, state_r == ST_OUT, "result overwritten")

endmodule

// ----- tb/g_limited_elevator_scaler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for g_limited_elevator_scaler: random and directed words on
// valid/ready channels, APB register writes, checked against a built-in scale predictor.
// Depends on gles_pkg and the g_limited_elevator_scaler RTL.
module g_limited_elevator_scaler_tb;
  import gles_pkg::*;

  localparam longint Q15_ONE  = ONE_Q15;
  localparam longint Q16_ONE  = ONE_Q16;
  localparam longint GAIN_MIN = GAIN_BASE;
  localparam longint SMOOTH_3 = SMOOTH_K;
  localparam longint Q16_HALF = ROUND_Q16;
  localparam longint Q15_HALF = ROUND_Q15;

  localparam int G_MIN     = -32768;
  localparam int G_MAX     = 32767;
  localparam int ALPHA_MAX = 25736;
  localparam int CMD_MAX   = 16384;

  typedef struct {
    logic signed [15:0] elev;
    logic [15:0]        scale;
  } elev_word_t;

  // Predicts the limit factor and filtered scale, and holds the words still due
  class elevator_scale_check;
    logic [14:0]        lim_high;
    logic signed [15:0] lim_low;
    logic [14:0]        band;
    logic [13:0]        stall;
    longint             scale;
    elev_word_t         due_words[$];
    int                 n_words, n_checked, n_bad, n_zero, n_band, n_full;

    function new();
      lim_high = G_LIMIT_HIGH_RST;
      lim_low  = G_LIMIT_LOW_RST;
      band     = GUARD_BAND_RST;
      stall    = STALL_ANGLE_RST;
      scale    = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_G_LIMIT_HIGH: lim_high = v[14:0];
        REG_G_LIMIT_LOW:  lim_low  = v[15:0];
        REG_GUARD_BAND:   band     = v[14:0];
        REG_STALL_ANGLE:  stall    = v[13:0];
        default: ;
      endcase
    endfunction

    // smoothstep of the fraction of the band still left before the limit
    function longint band_smoothstep(longint margin);
      longint t, t2;
      if (band == 0 || margin < 0) return 0;
      t = (margin <<< 15) / longint'(band);
      if (t > Q15_ONE) t = Q15_ONE;
      t2 = (t * t) >>> 15;
      return (t2 * (SMOOTH_3 - 2 * t)) >>> 15;
    endfunction

    function longint load_limit_factor(longint g, longint alpha, longint cmd);
      longint hi, lo, eps;
      hi  = longint'(lim_high);
      lo  = longint'(lim_low);
      eps = longint'(band);
      if (cmd > 0 && g > hi) return 0;
      if (cmd < 0 && g < lo) return 0;
      if (cmd > 0 && alpha > longint'(stall)) return 0;
      if (cmd > 0 && g > hi - eps) return band_smoothstep(hi - g);
      if (cmd < 0 && g < lo + eps) return band_smoothstep(g - lo);
      return Q15_ONE;
    endfunction

    // accepted input word: advance the filter and queue the expected output
    function void note_word(input logic signed [15:0] g, alpha, cmd, input logic [15:0] dt);
      longint     f, u, mix, prod;
      elev_word_t w;
      f = load_limit_factor(g, alpha, cmd);
      if (f == 0) n_zero++;
      else if (f == Q15_ONE) n_full++;
      else n_band++;
      u = GAIN_MIN + longint'(dt);
      if (u > Q16_ONE) u = Q16_ONE;
      mix   = (Q16_ONE - u) * scale + u * f + Q16_HALF;
      scale = mix >>> 16;
      if (scale > Q15_ONE) scale = Q15_ONE;
      prod    = longint'(cmd) * scale + Q15_HALF;
      w.elev  = 16'(prod >>> 15);
      w.scale = 16'(scale);
      due_words.push_back(w);
      n_words++;
    endfunction

    function void log_fault(string what);
      n_bad++;
      if (n_bad <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_word(logic signed [15:0] elev, logic [15:0] scale_out);
      elev_word_t w;
      if (due_words.size() == 0) begin
        log_fault($sformatf("unexpected word elevator_out=%0d scale_now=%0d", elev, scale_out));
        return;
      end
      w = due_words.pop_front();
      n_checked++;
      if (w.elev !== elev || w.scale !== scale_out)
        log_fault($sformatf("word %0d: elevator_out exp %0d got %0d, scale_now exp %0d got %0d",
                            n_checked, w.elev, elev, w.scale, scale_out));
    endfunction

    function void check_drained();
      if (due_words.size() != 0)
        log_fault($sformatf("%0d expected words never arrived", due_words.size()));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_g_load = '0;
  logic signed [15:0] in_attack_angle = '0;
  logic signed [15:0] in_elevator_command = '0;
  logic [15:0]        in_step_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_elevator_out;
  logic [15:0]        out_scale_now;

  int in_gap_pct = 0;
  int out_gap_pct = 0;
  int n_settings = 1;

  elevator_scale_check sb = new();

  g_limited_elevator_scaler i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: ready in random stretches, with stall bursts when enabled
  initial begin
    @(posedge clk);
    forever begin
      if (out_gap_pct > 0 && $urandom_range(0, 99) < out_gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_word(out_elevator_out, out_scale_now);

  function automatic int clip(int v, int lo_b, int hi_b);
    return (v < lo_b) ? lo_b : (v > hi_b) ? hi_b : v;
  endfunction

  function automatic int gap_pick();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // one input word, held until accepted
  task automatic send_word(int g, int alpha, int cmd, int dt);
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_g_load           <= 16'(g);
    in_attack_angle     <= 16'(alpha);
    in_elevator_command <= 16'(cmd);
    in_step_time        <= 16'(dt);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(in_g_load, in_attack_angle, in_elevator_command, in_step_time);
  endtask

  // APB write: setup, access, then back to idle
  task automatic apb_write(reg_idx_t idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // new register setting once every outstanding word has come back
  task automatic apply_setting(int hi, int lo, int bw, int st);
    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    apb_write(REG_G_LIMIT_HIGH, 32'(hi));
    apb_write(REG_G_LIMIT_LOW, 32'(lo));
    apb_write(REG_GUARD_BAND, 32'(bw));
    apb_write(REG_STALL_ANGLE, 32'(st));
    n_settings++;
    in_gap_pct  = gap_pick();
    out_gap_pct = gap_pick();
  endtask

  // loads on and around both limits and the stall angle of the current setting
  task automatic send_limit_cases();
    int hi, lo, bw, st;
    hi = sb.lim_high;
    lo = sb.lim_low;
    bw = sb.band;
    st = sb.stall;
    send_word(hi, 0, CMD_MAX, 2000);                              // on the high limit
    send_word(clip(hi + 1, G_MIN, G_MAX), 0, 9000, 2000);          // just past it
    send_word(clip(hi - bw, G_MIN, G_MAX), 0, CMD_MAX, 2000);      // band edge, still free
    send_word(clip(hi - bw + 1, G_MIN, G_MAX), st, CMD_MAX, 2000); // inside band, at stall
    send_word(lo, 0, -CMD_MAX, 2000);                             // on the low limit
    send_word(clip(lo - 1, G_MIN, G_MAX), 0, -1, 2000);
    send_word(clip(lo + bw - 1, G_MIN, G_MAX), 0, -12000, 2000);
    send_word(0, st + 1, CMD_MAX, 2000);                          // pulling above stall
  endtask

  // loads mostly near a limit, commands mostly toward it
  task automatic send_random_words(int count);
    int mode, g, alpha, cmd, dt, mag, hi, lo, bw, st;
    hi = sb.lim_high;
    lo = sb.lim_low;
    bw = sb.band;
    st = sb.stall;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) g = hi - bw - 8 + int'($urandom_range(0, bw + 16));
      else if (mode < 7) g = lo - 8 + int'($urandom_range(0, bw + 16));
      else g = int'($urandom_range(0, 65535)) - 32768;
      g = clip(g, G_MIN, G_MAX);
      mag = int'($urandom_range(1, CMD_MAX));
      case ($urandom_range(0, 19))
        0:       cmd = 0;
        1:       cmd = $urandom_range(0, 1) ? CMD_MAX : -CMD_MAX;
        2, 3, 4: cmd = int'($urandom_range(0, 2 * CMD_MAX)) - CMD_MAX;
        default: cmd = (mode >= 4 && mode < 7) ? -mag : mag;
      endcase
      if ($urandom_range(0, 3) == 0) alpha = int'($urandom_range(0, 2 * ALPHA_MAX)) - ALPHA_MAX;
      else alpha = clip(st - 64 + int'($urandom_range(0, 128)), -ALPHA_MAX, ALPHA_MAX);
      case ($urandom_range(0, 9))
        0:       dt = $urandom_range(0, 65535);
        1:       dt = $urandom_range(60000, 65535);
        default: dt = $urandom_range(0, 4000);
      endcase
      send_word(g, alpha, cmd, dt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_gap_pct  = 30;
    out_gap_pct = 30;

    // directed words under the reset setting
    send_word(0, 0, 0, 0);                            // no command, factor one
    send_word(G_MAX, 0, CMD_MAX, 65535);              // past high limit, gain saturated
    send_word(G_MIN, 0, -CMD_MAX, 62259);             // past low limit, gain exactly one
    send_word(9216, 0, CMD_MAX, 0);                   // on the high limit
    send_word(-3072, 0, -CMD_MAX, 0);                 // on the low limit
    send_word(8448, 0, CMD_MAX, 3000);                // mid band
    send_word(-2304, 0, -CMD_MAX, 3000);
    send_word(7680, 0, CMD_MAX, 100);                 // band edge, still free
    send_word(7681, 0, CMD_MAX, 100);
    send_word(0, 2868, CMD_MAX, 5000);                // above stall
    send_word(0, 2867, CMD_MAX, 5000);                // at stall
    send_word(0, ALPHA_MAX, -CMD_MAX, 5000);          // pushing ignores stall
    send_word(0, -ALPHA_MAX, CMD_MAX, 5000);
    send_word(1000, 0, 1, 20000);
    send_word(1000, 0, -1, 20000);
    send_word(0, 0, CMD_MAX, 65535);
    send_word(0, 0, -CMD_MAX, 0);
    send_word(G_MAX, ALPHA_MAX, 0, 65535);
    send_limit_cases();
    send_random_words(55);

    // widest limits
    apply_setting(32767, -32768, 16384, 12868);
    send_limit_cases();
    send_random_words(55);

    // all zero: no band, stall at zero
    apply_setting(0, 0, 0, 0);
    send_limit_cases();
    send_random_words(55);

    // band wider than the limits
    apply_setting(200, -150, 16384, 100);
    send_limit_cases();
    send_random_words(55);

    apply_setting($urandom_range(0, 32767), -int'($urandom_range(0, 32768)),
                  $urandom_range(0, 16384), $urandom_range(0, 12868));
    send_limit_cases();
    send_random_words(55);

    // one-count band
    apply_setting(2048, -2048, 1, 4096);
    send_limit_cases();
    send_random_words(55);

    // back to reset values, no idling on either side
    apply_setting(G_LIMIT_HIGH_RST, G_LIMIT_LOW_RST, GUARD_BAND_RST, STALL_ANGLE_RST);
    in_gap_pct  = 0;
    out_gap_pct = 0;
    send_limit_cases();
    send_random_words(55);

    in_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    sb.check_drained();

    $display("%0d words over %0d register settings: factor zero %0d, in band %0d, full %0d",
             sb.n_words, n_settings, sb.n_zero, sb.n_band, sb.n_full);
    $display("%0d result words checked, %0d mismatches", sb.n_checked, sb.n_bad);
    if (sb.n_bad == 0) $display("g_limited_elevator_scaler_tb passed");
    else $display("g_limited_elevator_scaler_tb failed");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout: handshakes stopped completing");
    $display("g_limited_elevator_scaler_tb failed");
    $finish;
  end

endmodule
